### hdl/spot_pkg.sv
//------------------------------------------------------------------------------
// spot_pkg
// Shared types and constants for the sorted price order table: field widths,
// request and status codes, controller states and the command and status
// bundles between the controller and the datapath.
//------------------------------------------------------------------------------
package spot_pkg;

   localparam int TYPE_W   = 3;
   localparam int PRICE_W  = 32;
   localparam int QTY_W    = 16;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;

   typedef enum logic [TYPE_W-1:0] {
      REQ_FRONT  = 3'd0,
      REQ_SORTED = 3'd1,
      REQ_DELETE = 3'd2,
      REQ_SEARCH = 3'd3,
      REQ_TOP    = 3'd4,
      REQ_LIST   = 3'd5
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT_UP,
      S_SHIFT_DN,
      S_LIST,
      S_RESP_ZERO,
      S_RESP_ENTRY
   } state_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_CLEAR,
      IDX_INC,
      IDX_DEC,
      IDX_COUNT
   } idx_op_type;

   typedef enum logic [1:0] {
      RD_SAME,
      RD_BELOW,
      RD_ABOVE
   } rd_ofs_type;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_REQ,
      SEL_MEM
   } rsp_sel_type;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   quantity;
   } entry_type;

   typedef struct packed {
      logic        req_take;
      idx_op_type  idx_op;
      rd_ofs_type  rd_ofs;
      logic        pos_clear;
      logic        pos_load;
      logic        qty_load;
      logic        wr_shift;
      logic        wr_new;
      logic        cnt_inc;
      logic        cnt_dec;
      logic        rsp_load;
      rsp_sel_type rsp_sel;
      status_type  rsp_status;
      logic        rsp_last;
   } ctl_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic idx_at_end;
      logic idx_at_pos;
      logic idx_last;
      logic price_greater;
      logic price_equal;
      logic rsp_free;
   } dp_sts_type;

endpackage

### hdl/spot_req_if.sv
//------------------------------------------------------------------------------
// spot_req_if
// Request channel of the sorted price order table: valid, ready and one
// request item.
//------------------------------------------------------------------------------
interface spot_req_if;
   logic                          valid;
   logic                          ready;
   logic [spot_pkg::TYPE_W-1:0]   req_type;
   logic [spot_pkg::PRICE_W-1:0]  price;
   logic [spot_pkg::QTY_W-1:0]    quantity;

   modport source (output valid, output req_type, output price, output quantity,
                   input ready);
   modport sink   (input valid, input req_type, input price, input quantity,
                   output ready);
endinterface

### hdl/spot_rsp_if.sv
//------------------------------------------------------------------------------
// spot_rsp_if
// Result channel of the sorted price order table: valid, ready and one
// result item.
//------------------------------------------------------------------------------
interface spot_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [spot_pkg::STATUS_W-1:0]  status;
   logic [spot_pkg::PRICE_W-1:0]   entry_price;
   logic [spot_pkg::QTY_W-1:0]     entry_quantity;
   logic [spot_pkg::POS_W-1:0]     entry_position;
   logic [spot_pkg::COUNT_W-1:0]   entry_count;
   logic                           last;

   modport source (output valid, output status, output entry_price,
                   output entry_quantity, output entry_position,
                   output entry_count, output last, input ready);
   modport sink   (input valid, input status, input entry_price,
                   input entry_quantity, input entry_position,
                   input entry_count, input last, output ready);
endinterface

### hdl/sorted_price_order_table.sv
//------------------------------------------------------------------------------
// sorted_price_order_table
// Ordered table of buy orders (price in cents, quantity) with insert, delete,
// search, top and list requests; a sorted insert keeps descending price order.
//------------------------------------------------------------------------------
// The table holds up to CAPACITY orders in an entry memory with one write and
// one read port, and works on one request at a time. A request is taken only
// while the sequencer is idle; its results leave through a result register,
// so the next request can be taken while the last result still waits for the
// sink. A request walks the memory one entry per cycle, though a list holds
// while the result register is still full. A sorted insert scans to the slot,
// then moves the tail up by one entry a cycle; an insert at the front only
// moves the tail up, and a refused insert walks nothing. List sends one result
// per held order, front first, with last set on the final one; every other
// request gives exactly one result. Entries at or above the held count never
// affect a result, so the memory needs no clearing after reset.
//------------------------------------------------------------------------------
module sorted_price_order_table #(
   parameter int CAPACITY = 16
) (
   input logic         clock,
   input logic         reset,
   spot_req_if.sink    req_chan,
   spot_rsp_if.source  rsp_chan
);
   import spot_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   // The sequencer owns all decisions; the datapath only reports compares
   // and counts back to it.
   spot_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Entry memory, walk index and result register.
   spot_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_price    (req_chan.price),
      .req_quantity (req_chan.quantity),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .rsp_status   (rsp_chan.status),
      .rsp_price    (rsp_chan.entry_price),
      .rsp_quantity (rsp_chan.entry_quantity),
      .rsp_position (rsp_chan.entry_position),
      .rsp_count    (rsp_chan.entry_count),
      .rsp_last     (rsp_chan.last)
   );

endmodule

### hdl/spot_datapath.sv
//------------------------------------------------------------------------------
// spot_datapath
// Entry memory, walk index, entry count, latched request and the result
// register of the sorted price order table.
//------------------------------------------------------------------------------
module spot_datapath #(
   parameter int CAPACITY = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  spot_pkg::ctl_cmd_type         cmd,
   output spot_pkg::dp_sts_type          sts,
   input  logic [spot_pkg::PRICE_W-1:0]  req_price,
   input  logic [spot_pkg::QTY_W-1:0]    req_quantity,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [spot_pkg::STATUS_W-1:0] rsp_status,
   output logic [spot_pkg::PRICE_W-1:0]  rsp_price,
   output logic [spot_pkg::QTY_W-1:0]    rsp_quantity,
   output logic [spot_pkg::POS_W-1:0]    rsp_position,
   output logic [spot_pkg::COUNT_W-1:0]  rsp_count,
   output logic                          rsp_last
);
   import spot_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   entry_type          mem [CAPACITY];
   entry_type          rd_data_ff;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   rd_full;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   pos_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [PRICE_W-1:0] price_ff;
   logic [QTY_W-1:0]   qty_ff;
   entry_type          wr_data;
   logic               wr_en;
   logic               rsp_free;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [PRICE_W-1:0]  rsp_price_ff;
   logic [QTY_W-1:0]    rsp_quantity_ff;
   logic [POS_W-1:0]    rsp_position_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_last_ff;

   // The read address follows the next index, one below or one above when asked,
   // so the registered read data lines up with the index register or a neighbour.
   always_comb begin
      case (cmd.idx_op)
         IDX_HOLD:  idx_in = idx_ff;
         IDX_CLEAR: idx_in = '0;
         IDX_INC:   idx_in = idx_ff + CNT_W'(1);
         IDX_DEC:   idx_in = idx_ff - CNT_W'(1);
         IDX_COUNT: idx_in = count_ff;
         default:   idx_in = idx_ff;
      endcase
      case (cmd.rd_ofs)
         RD_SAME:  rd_full = idx_in;
         RD_BELOW: rd_full = idx_in - CNT_W'(1);
         RD_ABOVE: rd_full = idx_in + CNT_W'(1);
         default:  rd_full = idx_in;
      endcase
      rd_addr = rd_full[IDX_W-1:0];
   end

   assign wr_en   = cmd.wr_shift | cmd.wr_new;
   assign wr_data = cmd.wr_new ? entry_type'{price: price_ff, quantity: qty_ff}
                               : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff[IDX_W-1:0]] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         count_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         if (cmd.cnt_inc) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.cnt_dec) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_take) begin
         price_ff <= req_price;
      end
      if (cmd.req_take) begin
         qty_ff <= req_quantity;
      end else if (cmd.qty_load) begin
         qty_ff <= rd_data_ff.quantity;
      end
      if (cmd.pos_clear) begin
         pos_ff <= '0;
      end else if (cmd.pos_load) begin
         pos_ff <= idx_ff[IDX_W-1:0];
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_count_ff  <= COUNT_W'(count_ff);
         rsp_last_ff   <= cmd.rsp_last;
         case (cmd.rsp_sel)
            SEL_REQ: begin
               rsp_price_ff    <= price_ff;
               rsp_quantity_ff <= qty_ff;
               rsp_position_ff <= POS_W'(pos_ff);
            end
            SEL_MEM: begin
               rsp_price_ff    <= rd_data_ff.price;
               rsp_quantity_ff <= rd_data_ff.quantity;
               rsp_position_ff <= POS_W'(idx_ff);
            end
            default: begin
               rsp_price_ff    <= '0;
               rsp_quantity_ff <= '0;
               rsp_position_ff <= '0;
            end
         endcase
      end
   end

   always_comb begin
      sts.count_zero    = (count_ff == '0);
      sts.count_full    = (count_ff == CNT_W'(CAPACITY));
      sts.idx_at_end    = (idx_ff == count_ff);
      sts.idx_at_pos    = (idx_ff == CNT_W'(pos_ff));
      sts.idx_last      = ((idx_ff + CNT_W'(1)) == count_ff);
      sts.price_greater = (rd_data_ff.price > price_ff);
      sts.price_equal   = (rd_data_ff.price == price_ff);
      sts.rsp_free      = rsp_free;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_price    = rsp_price_ff;
   assign rsp_quantity = rsp_quantity_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_last     = rsp_last_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> rsp_free)
      else $error("result register overwritten before it was taken");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_inc_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> (count_ff < CNT_W'(CAPACITY)))
      else $error("insert into a full table");

endmodule

### hdl/spot_controller.sv
//------------------------------------------------------------------------------
// spot_controller
// Request sequencer of the sorted price order table. Decodes each request and
// steps the datapath through scan, shift, list and result phases.
//------------------------------------------------------------------------------
module spot_controller (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [spot_pkg::TYPE_W-1:0] req_type,
   output logic                        req_ready,
   input  spot_pkg::dp_sts_type        sts,
   output spot_pkg::ctl_cmd_type       cmd
);
   import spot_pkg::*;

   state_type    state_ff, state_in;
   req_code_type op_ff, op_in;
   status_type   stat_ff, stat_in;
   logic         list_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= REQ_FRONT;
         stat_ff  <= STAT_OK;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         stat_ff  <= stat_in;
      end
   end

   assign list_last = (op_ff == REQ_TOP) || sts.idx_last;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      stat_in   = stat_ff;
      req_ready = 1'b0;
      cmd       = '0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_take = 1'b1;
               op_in        = req_code_type'(req_type);
               case (req_code_type'(req_type))
                  REQ_FRONT: begin
                     if (sts.count_full) begin
                        stat_in  = STAT_FULL;
                        state_in = S_RESP_ZERO;
                     end else begin
                        cmd.pos_clear = 1'b1;
                        cmd.idx_op    = IDX_COUNT;
                        cmd.rd_ofs    = RD_BELOW;
                        state_in      = S_SHIFT_UP;
                     end
                  end
                  REQ_SORTED: begin
                     if (sts.count_full) begin
                        stat_in  = STAT_FULL;
                        state_in = S_RESP_ZERO;
                     end else begin
                        cmd.idx_op = IDX_CLEAR;
                        state_in   = S_SCAN;
                     end
                  end
                  REQ_DELETE, REQ_SEARCH: begin
                     if (sts.count_zero) begin
                        stat_in  = STAT_EMPTY;
                        state_in = S_RESP_ZERO;
                     end else begin
                        cmd.idx_op = IDX_CLEAR;
                        state_in   = S_SCAN;
                     end
                  end
                  REQ_TOP, REQ_LIST: begin
                     if (sts.count_zero) begin
                        stat_in  = STAT_EMPTY;
                        state_in = S_RESP_ZERO;
                     end else begin
                        cmd.idx_op = IDX_CLEAR;
                        state_in   = S_LIST;
                     end
                  end
                  default: begin
                     stat_in  = STAT_OK;
                     state_in = S_RESP_ZERO;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (op_ff == REQ_SORTED) begin
               // Stop at the first entry whose price is not greater.
               if (sts.idx_at_end || !sts.price_greater) begin
                  cmd.pos_load = 1'b1;
                  cmd.idx_op   = IDX_COUNT;
                  cmd.rd_ofs   = RD_BELOW;
                  state_in     = S_SHIFT_UP;
               end else begin
                  cmd.idx_op = IDX_INC;
               end
            end else begin
               if (sts.idx_at_end) begin
                  stat_in  = STAT_NOT_FOUND;
                  state_in = S_RESP_ZERO;
               end else if (sts.price_equal) begin
                  cmd.pos_load = 1'b1;
                  cmd.qty_load = 1'b1;
                  stat_in      = STAT_OK;
                  if (op_ff == REQ_DELETE) begin
                     cmd.rd_ofs = RD_ABOVE;
                     state_in   = S_SHIFT_DN;
                  end else begin
                     state_in = S_RESP_ENTRY;
                  end
               end else begin
                  cmd.idx_op = IDX_INC;
               end
            end
         end

         S_SHIFT_UP: begin
            if (sts.idx_at_pos) begin
               cmd.wr_new  = 1'b1;
               cmd.cnt_inc = 1'b1;
               stat_in     = STAT_OK;
               state_in    = S_RESP_ENTRY;
            end else begin
               cmd.wr_shift = 1'b1;
               cmd.idx_op   = IDX_DEC;
               cmd.rd_ofs   = RD_BELOW;
            end
         end

         S_SHIFT_DN: begin
            if (sts.idx_last) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_RESP_ENTRY;
            end else begin
               cmd.wr_shift = 1'b1;
               cmd.idx_op   = IDX_INC;
               cmd.rd_ofs   = RD_ABOVE;
            end
         end

         S_LIST: begin
            if (sts.rsp_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_sel    = SEL_MEM;
               cmd.rsp_status = STAT_OK;
               cmd.rsp_last   = list_last;
               if (list_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_op = IDX_INC;
               end
            end
         end

         S_RESP_ZERO: begin
            if (sts.rsp_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_sel    = SEL_ZERO;
               cmd.rsp_status = stat_ff;
               cmd.rsp_last   = 1'b1;
               state_in       = S_IDLE;
            end
         end

         S_RESP_ENTRY: begin
            if (sts.rsp_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_sel    = SEL_REQ;
               cmd.rsp_status = stat_ff;
               cmd.rsp_last   = 1'b1;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> (state_ff != S_IDLE))
      else $error("accepted request did not start");

   a_shift_up_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT_UP) |-> !sts.count_full)
      else $error("shifting up in a full table");

   a_shift_dn_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT_DN) |-> !sts.count_zero)
      else $error("deleting from an empty table");

endmodule
